// ----- src/vwbp_pkg.sv -----
`default_nettype none

package vwbp_pkg;

    // Fixed field widths of the item and result channels
    localparam int VALUE_W = 32;
    localparam int WIDTH_W = 6;
    localparam int BYTE_W  = 8;

    // Default upper limit on the packed field width
    localparam int MAX_WIDTH_DEF = 32;

    // Buffer commands from the sequencer to the bit buffer
    typedef struct packed {
        logic load;   // merge a new field above the pending bits
        logic shift;  // drop the oldest byte
        logic clear;  // empty the buffer at the end of a stream
    } bb_ctrl_t;

endpackage

`default_nettype wire

// ----- src/vwbp_bit_buffer.sv -----
`default_nettype none

module vwbp_bit_buffer #(
    parameter int MAX_WIDTH = vwbp_pkg::MAX_WIDTH_DEF,
    localparam int CNT_W = $clog2(MAX_WIDTH + 8)
) (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire vwbp_pkg::bb_ctrl_t            ctrl,
    input  wire logic [vwbp_pkg::VALUE_W-1:0]  value,
    input  wire logic [vwbp_pkg::WIDTH_W-1:0]  width,
    output logic      [CNT_W-1:0]              count,
    output logic      [vwbp_pkg::BYTE_W-1:0]   low_byte
);

    localparam int BUF_W = MAX_WIDTH + 7;
    localparam int EXT_W = (MAX_WIDTH > vwbp_pkg::VALUE_W) ? MAX_WIDTH : vwbp_pkg::VALUE_W;

    logic [BUF_W-1:0]     buf_reg, buf_next;
    logic [CNT_W-1:0]     count_reg, count_next;
    logic [CNT_W-1:0]     w_sat;
    logic [EXT_W-1:0]     ext_value;
    logic [MAX_WIDTH-1:0] field;
    logic [BUF_W-1:0]     field_shifted;

    // Saturate the width and sign-extend the value
    always_comb begin
        if (width > vwbp_pkg::WIDTH_W'(MAX_WIDTH)) begin
            w_sat = CNT_W'(MAX_WIDTH);
        end else begin
            w_sat = CNT_W'(width);
        end
        for (int i = 0; i < EXT_W; i++) begin
            ext_value[i] = (i < vwbp_pkg::VALUE_W) ? value[i] : value[vwbp_pkg::VALUE_W-1];
        end
    end

    // Mask the field and place it above the pending bits
    always_comb begin
        for (int i = 0; i < MAX_WIDTH; i++) begin
            field[i] = ext_value[i] & (i < int'(w_sat));
        end
        field_shifted = BUF_W'(field) << count_reg[2:0];
    end

    // Shared buffer update: clear, merge or drop one byte
    always_comb begin
        buf_next   = buf_reg;
        count_next = count_reg;
        priority if (ctrl.clear) begin
            buf_next   = '0;
            count_next = '0;
        end else if (ctrl.load) begin
            buf_next   = buf_reg | field_shifted;
            count_next = count_reg + w_sat;
        end else if (ctrl.shift) begin
            buf_next   = buf_reg >> vwbp_pkg::BYTE_W;
            count_next = count_reg - CNT_W'(vwbp_pkg::BYTE_W);
        end else begin
            // Hold the pending bits
            buf_next   = buf_reg;
            count_next = count_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_reg   <= '0;
            count_reg <= '0;
        end else begin
            buf_reg   <= buf_next;
            count_reg <= count_next;
        end
    end

    assign count    = count_reg;
    assign low_byte = buf_reg[vwbp_pkg::BYTE_W-1:0];

endmodule

`default_nettype wire

// ----- src/vwbp_seq.sv -----
`default_nettype none

module vwbp_seq #(
    parameter int MAX_WIDTH = vwbp_pkg::MAX_WIDTH_DEF,
    localparam int CNT_W = $clog2(MAX_WIDTH + 8)
) (
    input  wire logic                         aclk,
    input  wire logic                         aresetn,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    input  wire logic                         s_tlast,
    input  wire logic [CNT_W-1:0]             count,
    input  wire logic [vwbp_pkg::BYTE_W-1:0]  low_byte,
    output vwbp_pkg::bb_ctrl_t                ctrl,
    output logic                              m_tvalid,
    input  wire logic                         m_tready,
    output logic      [vwbp_pkg::BYTE_W-1:0]  m_byte,
    output logic                              m_has_byte,
    output logic                              m_run_end,
    output logic                              m_stream_end
);

    typedef enum logic {
        ST_IDLE,
        ST_EMIT
    } state_t;

    state_t                      state_reg, state_next;
    logic                        last_reg, last_next;
    logic                        valid_reg, valid_next;
    logic [vwbp_pkg::BYTE_W-1:0] byte_reg, byte_next;
    logic                        has_reg, has_next;
    logic                        run_reg, run_next;
    logic                        stream_reg, stream_next;
    logic                        out_free;
    logic                        full_byte;
    logic [CNT_W-1:0]            remaining;
    logic                        item_done;

    assign out_free  = !valid_reg || m_tready;
    assign full_byte = count >= CNT_W'(vwbp_pkg::BYTE_W);
    assign remaining = count - CNT_W'(vwbp_pkg::BYTE_W);
    assign item_done = (remaining < CNT_W'(vwbp_pkg::BYTE_W))
                       && (!last_reg || remaining == '0);
    assign s_tready  = state_reg == ST_IDLE;

    // Sequence one byte per cycle out of the buffer while the output register is free
    always_comb begin
        state_next  = state_reg;
        last_next   = last_reg;
        valid_next  = valid_reg && !m_tready;
        byte_next   = byte_reg;
        has_next    = has_reg;
        run_next    = run_reg;
        stream_next = stream_reg;
        ctrl        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    ctrl.load  = 1'b1;
                    last_next  = s_tlast;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    priority if (full_byte) begin
                        // Emit a complete byte
                        ctrl.shift  = 1'b1;
                        ctrl.clear  = item_done && last_reg;
                        valid_next  = 1'b1;
                        byte_next   = low_byte;
                        has_next    = 1'b1;
                        run_next    = item_done;
                        stream_next = item_done && last_reg;
                        if (item_done) begin
                            state_next = ST_IDLE;
                        end
                    end else if (last_reg) begin
                        // Flush the padded partial byte or the empty end marker
                        ctrl.clear  = 1'b1;
                        valid_next  = 1'b1;
                        has_next    = count != '0;
                        byte_next   = (count != '0) ? low_byte : '0;
                        run_next    = 1'b1;
                        stream_next = 1'b1;
                        state_next  = ST_IDLE;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
        last_reg   <= last_next;
        byte_reg   <= byte_next;
        has_reg    <= has_next;
        run_reg    <= run_next;
        stream_reg <= stream_next;
    end

    assign m_tvalid     = valid_reg;
    assign m_byte       = byte_reg;
    assign m_has_byte   = has_reg;
    assign m_run_end    = run_reg;
    assign m_stream_end = stream_reg;

`ifndef SYNTH
    // The end of a stream always closes the item's run
    a_stream_closes_run: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && stream_reg |-> run_reg)
        else $error("stream end without run end");

    // An empty result is only the end marker and carries a zero byte
    a_empty_is_marker: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && !has_reg |-> stream_reg && byte_reg == '0)
        else $error("empty result is not a clean end marker");

    // Between items fewer than a byte of bits is pending
    a_idle_partial: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_IDLE |-> count < CNT_W'(vwbp_pkg::BYTE_W))
        else $error("whole byte left in buffer while idle");

    // A transfer in always starts the emit sequence
    a_accept_emits: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> state_reg == ST_EMIT)
        else $error("accepted item did not start emitting");
`endif

endmodule

`default_nettype wire

// ----- src/variable_width_bit_packer_top.sv -----
`default_nettype none

// LSB-first variable-width bit packer.
// Input channel s_*: one transfer carries a signed value and a field width;
// s_tlast marks the final item of a stream. The low width bits of the value
// (width saturated to MAX_WIDTH, 0 adds nothing) are appended above the
// pending bits, and each complete byte leaves on the m_* channel oldest first.
// On the last item the padded partial byte is flushed; if that item yields
// no byte, a single result with has_byte clear marks the stream end.
// m_tlast is set on the last result of each input item.
// Sequence: an item is first loaded into the bit buffer, then the shared
// shift-and-count unit sends one result per cycle while the output is free;
// a non-last item that yields no byte returns to idle without a result. The
// first byte is registered in the output register after the buffer load.
// s_tready is high only while the sequencer is idle.
// A stalled receiver holds the output register and pauses the sequencer; the
// next item may still be accepted while the final result waits.
// Reset (aresetn low, synchronous) empties the bit buffer and the output.
module variable_width_bit_packer_top #(
    parameter int MAX_WIDTH = vwbp_pkg::MAX_WIDTH_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,  // [31:0] value, [37:32] width, [39:38] zero
    input  wire logic        s_tlast,  // last
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [7:0]  m_tdata,  // [7:0] packed_byte
    output logic      [1:0]  m_tuser,  // [0] has_byte, [1] stream_end
    output logic             m_tlast   // run_end
);

    localparam int CNT_W = $clog2(MAX_WIDTH + 8);

    vwbp_pkg::bb_ctrl_t          ctrl;
    logic [CNT_W-1:0]            count;
    logic [vwbp_pkg::BYTE_W-1:0] low_byte;
    logic                        has_byte;
    logic                        stream_end;

    vwbp_bit_buffer #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_buffer (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .ctrl     (ctrl),
        .value    (s_tdata[vwbp_pkg::VALUE_W-1:0]),
        .width    (s_tdata[vwbp_pkg::VALUE_W +: vwbp_pkg::WIDTH_W]),
        .count    (count),
        .low_byte (low_byte)
    );

    vwbp_seq #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tlast      (s_tlast),
        .count        (count),
        .low_byte     (low_byte),
        .ctrl         (ctrl),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_byte       (m_tdata),
        .m_has_byte   (has_byte),
        .m_run_end    (m_tlast),
        .m_stream_end (stream_end)
    );

    assign m_tuser = {stream_end, has_byte};

endmodule

`default_nettype wire

// ----- test/tb_variable_width_bit_packer_top.sv -----
module tb_variable_width_bit_packer_top;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int HOLD_CYCLES    = 300;
    localparam int HOLD_AFTER     = 150;
    localparam int TAIL_CYCLES    = 12;

    // One input item and one packed result
    typedef struct packed {
        logic [vwbp_pkg::VALUE_W-1:0] value;
        logic [vwbp_pkg::WIDTH_W-1:0] width;
        logic                         last;
    } field_item_t;

    typedef struct packed {
        logic [vwbp_pkg::BYTE_W-1:0] data;
        logic                        has_byte;
        logic                        run_end;
        logic                        stream_end;
    } packed_byte_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;  // [31:0] value, [37:32] width, [39:38] zero
    logic        s_tlast  = 1'b0;  // last
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;  // [7:0] packed_byte
    logic [1:0]  m_tuser;  // [0] has_byte, [1] stream_end
    logic        m_tlast;  // run_end

    variable_width_bit_packer_top uut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #2 aclk = ~aclk;

    // Items waiting to be offered and bytes waiting to arrive
    field_item_t  fields_to_send [$];
    packed_byte_t bytes_due [$];

    // Shadow of the packer's pending bits
    logic [63:0] shadow_bits  = '0;
    int          shadow_count = 0;

    int errors        = 0;
    int items_in      = 0;
    int streams_in    = 0;
    int skipped_in    = 0;
    int bytes_checked = 0;
    int end_markers   = 0;
    int idle_cycles   = 0;

    // Work out the results of one accepted item and queue them
    task automatic pack_field(input logic [vwbp_pkg::VALUE_W-1:0] value,
                              input logic [vwbp_pkg::WIDTH_W-1:0] width, input logic last);
        logic [63:0]  ext;
        logic [63:0]  mask;
        int           w;
        int           n;
        packed_byte_t res [0:7];
        ext = {{32{value[vwbp_pkg::VALUE_W-1]}}, value};
        w   = int'(width);
        n   = 0;
        if (w > vwbp_pkg::MAX_WIDTH_DEF) w = vwbp_pkg::MAX_WIDTH_DEF;
        if (w > 0) begin
            mask = (w >= 64) ? '1 : ((64'd1 << w) - 64'd1);
            shadow_bits  = shadow_bits | ((ext & mask) << shadow_count);
            shadow_count = shadow_count + w;
            while (shadow_count >= 8) begin
                res[n] = '{data: shadow_bits[7:0], has_byte: 1'b1,
                           run_end: 1'b0, stream_end: 1'b0};
                n++;
                shadow_bits  = shadow_bits >> 8;
                shadow_count = shadow_count - 8;
            end
        end
        if (last) begin
            // Flush the padded partial byte, or mark an empty end
            if (shadow_count > 0) begin
                res[n] = '{data: shadow_bits[7:0], has_byte: 1'b1,
                           run_end: 1'b0, stream_end: 1'b0};
                n++;
            end
            if (n == 0) begin
                res[0] = '{data: 8'h00, has_byte: 1'b0, run_end: 1'b1, stream_end: 1'b1};
                n = 1;
            end else begin
                res[n-1].stream_end = 1'b1;
            end
            shadow_bits  = '0;
            shadow_count = 0;
        end
        if (n > 0) res[n-1].run_end = 1'b1;
        for (int i = 0; i < n; i++) bytes_due.push_back(res[i]);
    endtask

    task automatic add_field(input logic [31:0] value, input int width, input logic last);
        field_item_t it;
        it.value = value;
        it.width = width[vwbp_pkg::WIDTH_W-1:0];
        it.last  = last;
        fields_to_send.push_back(it);
    endtask

    // Sender: bursts of transfers with random gaps between them
    int burst_left = 4;
    int gap_left   = 0;
    field_item_t next_field;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                pack_field(s_tdata[31:0], s_tdata[37:32], s_tlast);
                if (s_tdata[37:32] == 0 && !s_tlast) skipped_in++;
                else items_in++;
                if (s_tlast) streams_in++;
            end
            if (!s_tvalid || s_tready) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (fields_to_send.size() > 0) begin
                    next_field = fields_to_send.pop_front();
                    s_tdata  <= {2'b00, next_field.width, next_field.value};
                    s_tlast  <= next_field.last;
                    s_tvalid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0) begin
                        burst_left = $urandom_range(1, 20);
                        gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: stall pattern picked at random from four modes, one long hold-off
    int ready_mode  = 0;
    int ready_phase = 0;
    int hold_left   = 0;
    bit hold_done   = 1'b0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            ready_phase++;
            if (ready_phase % 64 == 0) ready_mode = $urandom_range(0, 3);
            if (!hold_done && items_in >= HOLD_AFTER) begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                case (ready_mode)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 1) == 1);
                    2: m_tready <= (ready_phase % 4 == 0);
                    default: m_tready <= ($urandom_range(0, 99) < 85);
                endcase
            end
        end
    end

    // Check each result transfer against the oldest expected byte
    packed_byte_t want;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                if (bytes_due.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result: byte %02h has %0b run_end %0b %s %0b",
                             $time, m_tdata, m_tuser[0], m_tlast, "stream_end", m_tuser[1]);
                end else begin
                    want = bytes_due.pop_front();
                    if (m_tdata !== want.data || m_tuser[0] !== want.has_byte ||
                        m_tlast !== want.run_end || m_tuser[1] !== want.stream_end) begin
                        errors++;
                        $display("%0t: mismatch: expected byte %02h has %0b run_end %0b %s %0b",
                                 $time, want.data, want.has_byte, want.run_end,
                                 "stream_end", want.stream_end);
                        $display("%0t:           actual   byte %02h has %0b run_end %0b %s %0b",
                                 $time, m_tdata, m_tuser[0], m_tlast,
                                 "stream_end", m_tuser[1]);
                    end
                    if (!want.has_byte) end_markers++;
                end
                bytes_checked++;
            end
            // Watchdog on cycles with no transfer on either side
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
                if (idle_cycles >= WATCHDOG_LIMIT) begin
                    $display("%0t: timeout, no transfer for %0d cycles", $time, idle_cycles);
                    $display("FAIL");
                    $finish;
                end
            end
        end
    end

    // Fill the stimulus, release reset, wait for the drain
    initial begin
        int len;
        int pick;
        int w;
        int rand_items;
        logic [31:0] v;

        // Empty stream: a lone last item with zero width
        add_field(32'h0000_0000, 0, 1'b1);
        // Full-width extremes, ending exactly on a byte boundary
        add_field(32'h7FFF_FFFF, 32, 1'b0);
        add_field(32'h8000_0000, 32, 1'b1);
        // Single bit, skipped item, then a flushed partial byte
        add_field(32'hFFFF_FFFF, 1, 1'b0);
        add_field(32'hFFFF_FFFF, 0, 1'b0);
        add_field(32'h0000_0005, 3, 1'b1);
        // Widths above the limit saturate
        add_field(32'hFFFF_FFFF, 63, 1'b0);
        add_field(32'h1234_5678, 33, 1'b1);
        // Fill a byte across two items, then end with a bare last item
        add_field(32'h0000_0055, 7, 1'b0);
        add_field(32'h0000_0001, 1, 1'b0);
        add_field(32'h0000_0000, 0, 1'b1);
        // Partial bits left over, flushed by a zero-width last item
        add_field(32'h0000_000A, 4, 1'b0);
        add_field(32'hDEAD_BEEF, 0, 1'b1);
        // Small negative value as the only field
        add_field(32'hFFFF_FFF0, 5, 1'b1);
        // Mixed widths
        add_field(32'h0000_0000, 32, 1'b0);
        add_field(32'h5555_5555, 31, 1'b0);
        add_field(32'hAAAA_AAAA, 2, 1'b1);
        add_field(32'hCAFE_F00D, 40, 1'b0);
        add_field(32'h8000_0001, 17, 1'b1);

        // Random streams of random fields
        rand_items = 0;
        while (rand_items < 340) begin
            len = $urandom_range(1, 12);
            for (int k = 0; k < len; k++) begin
                pick = $urandom_range(0, 99);
                if (pick < 8) w = 0;
                else if (pick < 14) w = $urandom_range(33, 63);
                else if (pick < 40) w = 32;
                else w = $urandom_range(1, 31);
                pick = $urandom_range(0, 19);
                if (pick == 0) v = 32'h8000_0000;
                else if (pick == 1) v = 32'h7FFF_FFFF;
                else if (pick == 2) v = 32'hFFFF_FFFF;
                else if (pick == 3) v = 32'h0000_0000;
                else v = $urandom;
                add_field(v, w, k == len - 1);
                if (w != 0 || k == len - 1) rand_items++;
            end
            // Occasional stray zero-width item between streams
            if ($urandom_range(0, 9) == 0) add_field($urandom, 0, 1'b0);
        end

        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        // Sample between edges so the sender and checker have settled
        while (fields_to_send.size() != 0 || s_tvalid || bytes_due.size() != 0)
            @(negedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Run covered %0d items (%0d skipped) over %0d streams.",
                 items_in, skipped_in, streams_in);
        $display("Checked %0d results, %0d of them empty end markers, %0d errors.",
                 bytes_checked, end_markers, errors);
        if (errors == 0 && bytes_due.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
